// ===== hw/rtl/bfsp_pkg.sv =====
// Shared constants, types and result codes of the Bellman-Ford shortest path unit.
// No dependencies; every other file of the block imports this package.
package bfsp_pkg;

  // Sizes of the edge store and the node distance table.
  localparam int MAX_NODES  = 1024;
  localparam int MAX_EDGES  = 4096;
  localparam int NODE_W     = $clog2(MAX_NODES);
  localparam int NODE_CNT_W = NODE_W + 1;
  localparam int EDGE_AW    = $clog2(MAX_EDGES);
  localparam int EDGE_CNT_W = EDGE_AW + 1;
  localparam int WEIGHT_W   = 16;
  localparam int DIST_W     = 32;

  // Saturation limits of a tentative distance.
  localparam logic signed [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
  localparam logic signed [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

  // Result status codes.
  localparam logic [1:0] STATUS_OK          = 2'd0;
  localparam logic [1:0] STATUS_UNREACHABLE = 2'd1;
  localparam logic [1:0] STATUS_NEG_CYCLE   = 2'd2;

  // One stored edge.
  typedef struct packed {
    logic [NODE_W-1:0]          src;
    logic [NODE_W-1:0]          dst;
    logic signed [WEIGHT_W-1:0] weight;
  } edge_t;

  // One entry of the distance table.
  typedef struct packed {
    logic                     reached;
    logic signed [DIST_W-1:0] path_len;
  } dist_t;

  // Write port of the distance table.
  typedef struct packed {
    logic              en;
    logic [NODE_W-1:0] addr;
    dist_t             data;
  } dist_wr_t;

  // Result offered by the search engine to the output register.
  typedef struct packed {
    logic              valid;
    logic [1:0]        status;
    logic [DIST_W-1:0] distance;
  } res_t;

endpackage

// ===== hw/rtl/bfsp_edge_mem.sv =====
// Edge store: one write port for loading, one registered read port for the search.
// Depends on bfsp_pkg for the edge type and sizes.
module bfsp_edge_mem import bfsp_pkg::*; (
  input  logic               clk,
  input  logic               we,
  input  logic [EDGE_AW-1:0] waddr,
  input  edge_t              wdata,
  input  logic [EDGE_AW-1:0] raddr,
  output edge_t              rdata
);

  edge_t mem [MAX_EDGES];

  // Write on load; the read is registered and happens every cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/bfsp_dist_mem.sv =====
// Node distance table: one write port and two registered read ports.
// Depends on bfsp_pkg for the entry and write port types.
module bfsp_dist_mem import bfsp_pkg::*; (
  input  logic              clk,
  input  dist_wr_t          wr,
  input  logic [NODE_W-1:0] raddr_a,
  input  logic [NODE_W-1:0] raddr_b,
  output dist_t             rdata_a,
  output dist_t             rdata_b
);

  dist_t mem [MAX_NODES];

  // Both reads see the array as it was before this cycle's write.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== hw/rtl/bfsp_search.sv =====
// Search sequencer and relaxation datapath of the shortest path unit.
// Depends on bfsp_pkg and instantiates bfsp_dist_mem; reads the edge store.
module bfsp_search import bfsp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [NODE_CNT_W-1:0] node_count,
  input  logic [EDGE_CNT_W-1:0] edge_count,
  output logic [EDGE_AW-1:0]    edge_raddr,
  input  edge_t                 edge_rdata,
  output res_t                  res,
  input  logic                  res_take
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_CLEAR    = 4'd1;
  localparam logic [3:0] S_FETCH    = 4'd2;
  localparam logic [3:0] S_LOOKUP   = 4'd3;
  localparam logic [3:0] S_RELAX    = 4'd4;
  localparam logic [3:0] S_PASS_END = 4'd5;
  localparam logic [3:0] S_TREAD    = 4'd6;
  localparam logic [3:0] S_TRES     = 4'd7;
  localparam logic [3:0] S_DONE     = 4'd8;

  logic [3:0]            state;
  logic [NODE_W-1:0]     clr_idx;
  logic [EDGE_AW-1:0]    edge_idx;
  logic [NODE_W-1:0]     pass_cnt;
  logic                  check_pass;
  logic                  changed;
  logic                  hit_low;
  logic                  negative;
  logic [NODE_CNT_W-1:0] nodes_eff;
  logic [1:0]            res_status;
  logic [DIST_W-1:0]     res_distance;

  logic [NODE_CNT_W-1:0] nodes_clamped;
  logic [NODE_CNT_W-1:0] nodes_last;
  logic [NODE_W-1:0]     target;
  dist_t                 du;
  dist_t                 dv;
  dist_wr_t              dist_wr;
  logic [NODE_W-1:0]     dist_raddr_a;
  logic                  src_ok;
  logic                  dst_ok;
  logic                  live;
  logic [DIST_W:0]       sum;
  logic                  ovf_hi;
  logic                  ovf_lo;
  logic signed [DIST_W-1:0] sat;
  logic                  improves;
  logic                  last_in_pass;
  logic                  last_pass;
  logic                  no_edges;

  // Node count in use: zero acts as one, anything above the table acts as full.
  always_comb begin
    if (node_count == '0) begin
      nodes_clamped = NODE_CNT_W'(1);
    end else if (node_count > NODE_CNT_W'(MAX_NODES)) begin
      nodes_clamped = NODE_CNT_W'(MAX_NODES);
    end else begin
      nodes_clamped = node_count;
    end
  end

  assign nodes_last = nodes_eff - NODE_CNT_W'(1);
  assign target     = nodes_last[NODE_W-1:0];
  assign no_edges   = (edge_count == '0);

  // The edge store is read continuously at the current edge index.
  assign edge_raddr = edge_idx;

  // Source and target lookups; the target node is read once at the end.
  assign dist_raddr_a = (state == S_TREAD) ? target : edge_rdata.src;

  bfsp_dist_mem u_dist_mem (
    .clk     (clk),
    .wr      (dist_wr),
    .raddr_a (dist_raddr_a),
    .raddr_b (edge_rdata.dst),
    .rdata_a (du),
    .rdata_b (dv)
  );

  // Relaxation: saturated tentative distance and the improvement test.
  assign src_ok = {1'b0, edge_rdata.src} < nodes_eff;
  assign dst_ok = {1'b0, edge_rdata.dst} < nodes_eff;
  assign live   = src_ok && dst_ok && du.reached;
  assign sum    = {du.path_len[DIST_W-1], du.path_len}
                + {{(DIST_W+1-WEIGHT_W){edge_rdata.weight[WEIGHT_W-1]}}, edge_rdata.weight};
  assign ovf_hi = !sum[DIST_W] && sum[DIST_W-1];
  assign ovf_lo = sum[DIST_W] && !sum[DIST_W-1];

  always_comb begin
    if (ovf_hi) begin
      sat = DIST_MAX;
    end else if (ovf_lo) begin
      sat = DIST_MIN;
    end else begin
      sat = sum[DIST_W-1:0];
    end
  end

  assign improves     = live && (!dv.reached || (sat < dv.path_len));
  assign last_in_pass = ({1'b0, edge_idx} + EDGE_CNT_W'(1)) == edge_count;
  assign last_pass    = ({1'b0, pass_cnt} + NODE_CNT_W'(1)) == nodes_last;

  // Distance table writes: the clearing sweep and accepted relaxations.
  always_comb begin
    dist_wr = '0;
    if (state == S_CLEAR) begin
      dist_wr.en               = 1'b1;
      dist_wr.addr             = clr_idx;
      dist_wr.data.reached     = (clr_idx == '0);
      dist_wr.data.path_len    = '0;
    end else if (state == S_RELAX && !check_pass && improves) begin
      dist_wr.en               = 1'b1;
      dist_wr.addr             = edge_rdata.dst;
      dist_wr.data.reached     = 1'b1;
      dist_wr.data.path_len    = sat;
    end
  end

  // Result offered to the output register.
  assign res.valid    = (state == S_DONE);
  assign res.status   = res_status;
  assign res.distance = res_distance;

  // Sequencer. Each edge passes the fetch, lookup and relax states, and the next edge
  // is read only after the previous write, so lookups never see a stale entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      clr_idx    <= '0;
      edge_idx   <= '0;
      pass_cnt   <= '0;
      check_pass <= 1'b0;
      changed    <= 1'b0;
      hit_low    <= 1'b0;
      negative   <= 1'b0;
      nodes_eff  <= NODE_CNT_W'(MAX_NODES);
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            nodes_eff  <= nodes_clamped;
            clr_idx    <= '0;
            pass_cnt   <= '0;
            hit_low    <= 1'b0;
            negative   <= 1'b0;
            state      <= S_CLEAR;
          end
        end

        // Mark every node in use unreached, node 0 reached at zero.
        S_CLEAR: begin
          clr_idx <= clr_idx + NODE_W'(1);
          if ({1'b0, clr_idx} == nodes_last) begin
            check_pass <= (nodes_eff == NODE_CNT_W'(1));
            changed    <= 1'b0;
            edge_idx   <= '0;
            state      <= no_edges ? S_PASS_END : S_FETCH;
          end
        end

        S_FETCH: begin
          state <= S_LOOKUP;
        end

        S_LOOKUP: begin
          state <= S_RELAX;
        end

        S_RELAX: begin
          if (live && ovf_lo) begin
            hit_low <= 1'b1;
          end
          if (check_pass && improves) begin
            // Any edge that still relaxes proves a reachable negative cycle.
            negative <= 1'b1;
            state    <= S_TREAD;
          end else begin
            if (improves) begin
              changed <= 1'b1;
            end
            if (last_in_pass) begin
              state <= S_PASS_END;
            end else begin
              edge_idx <= edge_idx + EDGE_AW'(1);
              state    <= S_FETCH;
            end
          end
        end

        // Stop after the check pass, or start the next pass.
        S_PASS_END: begin
          if (check_pass) begin
            state <= S_TREAD;
          end else begin
            pass_cnt <= pass_cnt + NODE_W'(1);
            if (!changed || last_pass) begin
              check_pass <= 1'b1;
            end
            changed  <= 1'b0;
            edge_idx <= '0;
            state    <= no_edges ? S_PASS_END : S_FETCH;
          end
        end

        S_TREAD: begin
          state <= S_TRES;
        end

        S_TRES: begin
          if (negative || hit_low) begin
            res_status   <= STATUS_NEG_CYCLE;
            res_distance <= '0;
          end else if (!du.reached) begin
            res_status   <= STATUS_UNREACHABLE;
            res_distance <= '0;
          end else begin
            res_status   <= STATUS_OK;
            res_distance <= du.path_len;
          end
          state <= S_DONE;
        end

        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/bellman_ford_shortest_path_unit.sv =====
// Top level of the Bellman-Ford shortest path unit: load path, config and output register.
// Depends on bfsp_pkg; instantiates bfsp_edge_mem and bfsp_search.
//
//   Channel   Direction  Handshake             Payload
//   edge      in         edge_valid/edge_stall edge_source, edge_target, edge_weight, last_edge
//   result    out        result_valid/result_stall status, distance
//   cfg       in         cfg_we                cfg_wdata (node_count)
//
// Edges load at one per cycle into the edge store while no search runs.
// A marked edge starts the search: it clears the distance table, then runs
// relaxation passes over the loaded edges until a pass changes nothing or the
// pass limit set by the node count is reached, then a check pass, then reads the target node.
// The edge channel stalls from the marked edge until its result reaches the
// output register; a stalled result holds while new edges keep loading.
// Reset is synchronous and clears the edge count, the search and node_count to 1024.
module bellman_ford_shortest_path_unit import bfsp_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [NODE_CNT_W-1:0]      cfg_wdata,
  input  logic                       edge_valid,
  output logic                       edge_stall,
  input  logic [NODE_W-1:0]          edge_source,
  input  logic [NODE_W-1:0]          edge_target,
  input  logic signed [WEIGHT_W-1:0] edge_weight,
  input  logic                       last_edge,
  output logic                       result_valid,
  input  logic                       result_stall,
  output logic [1:0]                 status,
  output logic signed [DIST_W-1:0]   distance
);

  logic [NODE_CNT_W-1:0] node_count;
  logic [EDGE_CNT_W-1:0] edges_loaded;
  logic                  busy;

  logic                  edge_accept;
  logic                  store_we;
  edge_t                 store_wdata;
  logic [EDGE_AW-1:0]    edge_raddr;
  edge_t                 edge_rdata;
  res_t                  res;
  logic                  res_take;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODE_CNT_W'(MAX_NODES);
    end else if (cfg_we) begin
      node_count <= cfg_wdata;
    end
  end

  // Edge load: edges past a full store are dropped but the mark still counts.
  assign edge_stall  = busy;
  assign edge_accept = edge_valid && !busy;
  assign store_we    = edge_accept && (edges_loaded < EDGE_CNT_W'(MAX_EDGES));

  assign store_wdata.src    = edge_source;
  assign store_wdata.dst    = edge_target;
  assign store_wdata.weight = edge_weight;

  bfsp_edge_mem u_edge_mem (
    .clk   (clk),
    .we    (store_we),
    .waddr (edges_loaded[EDGE_AW-1:0]),
    .wdata (store_wdata),
    .raddr (edge_raddr),
    .rdata (edge_rdata)
  );

  bfsp_search u_search (
    .clk        (clk),
    .rst        (rst),
    .start      (edge_accept && last_edge),
    .node_count (node_count),
    .edge_count (edges_loaded),
    .edge_raddr (edge_raddr),
    .edge_rdata (edge_rdata),
    .res        (res),
    .res_take   (res_take)
  );

  // A finished result moves to the output register once that register is free.
  assign res_take = res.valid && (!result_valid || !result_stall);

  // Edge count and search flag; the edge list empties with each result.
  always_ff @(posedge clk) begin
    if (rst) begin
      edges_loaded <= '0;
      busy         <= 1'b0;
    end else if (res_take) begin
      edges_loaded <= '0;
      busy         <= 1'b0;
    end else if (edge_accept) begin
      if (store_we) begin
        edges_loaded <= edges_loaded + EDGE_CNT_W'(1);
      end
      if (last_edge) begin
        busy <= 1'b1;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_take) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      status   <= res.status;
      distance <= res.distance;
    end
  end

endmodule

// ===== hw/rtl/bfsp_checker.sv =====
// Port-level checks of the Bellman-Ford shortest path unit, bound to the top level.
// Depends on bfsp_pkg for sizes and status codes.
module bfsp_checker import bfsp_pkg::*; (
  input logic                       clk,
  input logic                       rst,
  input logic                       edge_valid,
  input logic                       edge_stall,
  input logic                       last_edge,
  input logic                       result_valid,
  input logic                       result_stall,
  input logic [1:0]                 status,
  input logic signed [DIST_W-1:0]   distance
);

  // A stalled result transaction holds its payload.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(status) && $stable(distance))
    else $error("result changed while stalled");

  // A marked edge starts a search, which stalls the edge channel.
  assert property (@(posedge clk) disable iff (rst)
    edge_valid && !edge_stall && last_edge |=> edge_stall)
    else $error("search did not start after the marked edge");

  // An unmarked edge leaves the load path open.
  assert property (@(posedge clk) disable iff (rst)
    edge_valid && !edge_stall && !last_edge |=> !edge_stall)
    else $error("edge channel stalled without a search");

  // A new result only appears as a search ends.
  assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(edge_stall) && !edge_stall)
    else $error("result without a finished search");

  // A valid result with a status other than OK carries a zero distance.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && status != STATUS_OK |-> distance == '0)
    else $error("distance not cleared for a failed search");

endmodule

bind bellman_ford_shortest_path_unit bfsp_checker u_bfsp_checker (
  .clk          (clk),
  .rst          (rst),
  .edge_valid   (edge_valid),
  .edge_stall   (edge_stall),
  .last_edge    (last_edge),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .status       (status),
  .distance     (distance)
);
